// ----- rtl/duplicate_frame_filter_defines.svh -----
// Assertion macros shared by the duplicate frame filter RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef DUPLICATE_FRAME_FILTER_DEFINES_SVH
`define DUPLICATE_FRAME_FILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DFF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DFF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/dff_pkg.sv -----
// Types and constants of the duplicate frame filter.
// Depends on nothing; used by the cell, the top level and the testbench.
`default_nettype none
package dff_pkg;

	localparam int DFF_TABLE_ENTRIES = 16;
	localparam int DFF_WINDOW_BITS   = 32;
	localparam int DFF_IDX_MAX_W     = 8;
	localparam int DFF_CNT_MAX_W     = 9;
	localparam int DFF_WIN_MAX_W     = 32;
	localparam logic [31:0] DFF_HALF_RANGE = 32'h8000_0000;
	localparam logic [4:0]  DFF_USED_MAX   = 5'd31;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} dff_state_t;

	typedef struct packed {
		logic [31:0] peer_id;
		logic [31:0] peer_epoch;
	} dff_key_t;

	typedef struct packed {
		logic                     hit;
		logic [DFF_IDX_MAX_W-1:0] hit_idx;
		logic [31:0]              hit_highest;
		logic [DFF_WIN_MAX_W-1:0] hit_bitmap;
		logic                     same;
		logic [DFF_IDX_MAX_W-1:0] same_idx;
		logic                     free;
		logic [DFF_IDX_MAX_W-1:0] free_idx;
		logic                     lru;
		logic [DFF_IDX_MAX_W-1:0] lru_idx;
		logic [31:0]              lru_stamp;
		logic [DFF_CNT_MAX_W-1:0] used;
	} dff_scan_t;

	typedef struct packed {
		logic                     en;
		logic [DFF_IDX_MAX_W-1:0] idx;
		logic [31:0]              peer_id;
		logic [31:0]              peer_epoch;
		logic [31:0]              highest;
		logic [DFF_WIN_MAX_W-1:0] bitmap;
		logic [31:0]              stamp;
	} dff_wr_t;

endpackage
`default_nettype wire

// ----- rtl/dff_if.sv -----
// Request and result channel interfaces of the duplicate frame filter.
// Depends on nothing but the clockless valid/ready handshake.
`default_nettype none
interface dff_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] peer_id;
	logic [31:0] peer_epoch;
	logic [31:0] sequence_req;
	modport source (output valid, peer_id, peer_epoch, sequence_req, input ready);
	modport sink (input valid, peer_id, peer_epoch, sequence_req, output ready);
endinterface

interface dff_rsp_if;
	logic        valid;
	logic        ready;
	logic        verdict;
	logic        opened_entry;
	logic        evicted;
	logic [4:0]  entries_used;
	logic [31:0] eviction_count;
	modport source (output valid, verdict, opened_entry, evicted, entries_used,
		eviction_count, input ready);
	modport sink (input valid, verdict, opened_entry, evicted, entries_used,
		eviction_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/dff_cell.sv -----
// One table slot of the duplicate frame filter and its step of the scan chain.
// Depends on dff_pkg.
`default_nettype none
module dff_cell import dff_pkg::*; #(
	parameter int WINDOW_BITS = DFF_WINDOW_BITS,
	parameter int CELL_ID     = 0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire dff_key_t  key,
	input  wire dff_scan_t scan_in,
	input  wire logic      scan_in_valid,
	output dff_scan_t      scan_out,
	output logic           scan_out_valid,
	input  wire dff_wr_t   wr
);

	localparam logic [DFF_IDX_MAX_W-1:0] ID = DFF_IDX_MAX_W'(CELL_ID);

	logic [31:0]            stamp_q;
	logic [31:0]            source_q;
	logic [31:0]            session_q;
	logic [31:0]            highest_q;
	logic [WINDOW_BITS-1:0] bitmap_q;
	dff_scan_t              scan_q;
	logic                   scan_valid_q;
	dff_scan_t              scan_c;
	logic                   live;
	logic                   wr_here;

	assign live    = (stamp_q != 32'd0);
	assign wr_here = wr.en && (wr.idx == ID);

	always_comb begin
		scan_c = scan_in;
		if (live) begin
			scan_c.used = scan_in.used + DFF_CNT_MAX_W'(1);
		end
		if (!scan_in.hit) begin
			if (!live) begin
				if (!scan_in.free) begin
					scan_c.free     = 1'b1;
					scan_c.free_idx = ID;
				end
			end else begin
				if (source_q == key.peer_id) begin
					if (session_q == key.peer_epoch) begin
						scan_c.hit         = 1'b1;
						scan_c.hit_idx     = ID;
						scan_c.hit_highest = highest_q;
						scan_c.hit_bitmap  = DFF_WIN_MAX_W'(bitmap_q);
					end else begin
						scan_c.same     = 1'b1;
						scan_c.same_idx = ID;
					end
				end
				if (!scan_in.lru || (stamp_q < scan_in.lru_stamp)) begin
					scan_c.lru       = 1'b1;
					scan_c.lru_idx   = ID;
					scan_c.lru_stamp = stamp_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q      <= 32'd0;
			scan_valid_q <= 1'b0;
		end else begin
			scan_valid_q <= scan_in_valid;
			if (wr_here) begin
				stamp_q <= wr.stamp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_in_valid) begin
			scan_q <= scan_c;
		end
		if (wr_here) begin
			source_q  <= wr.peer_id;
			session_q <= wr.peer_epoch;
			highest_q <= wr.highest;
			bitmap_q  <= wr.bitmap[WINDOW_BITS-1:0];
		end
	end

	assign scan_out       = scan_q;
	assign scan_out_valid = scan_valid_q;

endmodule
`default_nettype wire

// ----- rtl/duplicate_frame_filter.sv -----
// Duplicate frame filter: one request is taken, scanned through a chain of
// TABLE_ENTRIES slot cells at one cell per cycle, then its slot is written and
// the result registered once the result register is free. No new request is
// taken until that write; the result register lets the next request enter
// while a result waits to be taken.
// Depends on dff_pkg, dff_if, dff_cell and duplicate_frame_filter_defines.svh.
`default_nettype none
`include "duplicate_frame_filter_defines.svh"
module duplicate_frame_filter import dff_pkg::*; #(
	parameter int TABLE_ENTRIES = DFF_TABLE_ENTRIES,
	parameter int WINDOW_BITS   = DFF_WINDOW_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	dff_req_if.sink   req,
	dff_rsp_if.source rsp
);

	localparam int WB = WINDOW_BITS;
	localparam logic [WB-1:0] TOP_BIT = WB'(1) << (WB - 1);
	localparam logic [WB-1:0] ONE_BIT = WB'(1);

	dff_state_t  state_q, state_d;
	dff_key_t    key_q;
	dff_key_t    key_c;
	logic [31:0] seq_q;
	logic [31:0] stamp_q;
	logic [31:0] evict_q;

	dff_scan_t scan_chain [TABLE_ENTRIES+1];
	logic      valid_chain [TABLE_ENTRIES+1];
	dff_scan_t fin;
	dff_wr_t   wr;

	logic                     accept;
	logic                     out_free;
	logic                     commit;
	logic                     opened_c;
	logic                     evict_c;
	logic                     verdict_c;
	logic [DFF_IDX_MAX_W-1:0] target_c;
	logic [31:0]              new_hi_c;
	logic [WB-1:0]            new_bm_c;
	logic [WB-1:0]            old_bm;
	logic [WB-1:0]            probe;
	logic [31:0]              adv;
	logic [31:0]              age;
	logic [DFF_CNT_MAX_W-1:0] used_c;
	logic [4:0]               used_sat;

	logic        out_valid_q;
	logic        verdict_q;
	logic        opened_q;
	logic        evicted_q;
	logic [4:0]  used_q;

	assign scan_chain[0]  = '0;
	assign valid_chain[0] = accept;
	assign fin            = scan_chain[TABLE_ENTRIES];

	always_comb begin
		key_c = key_q;
		if (accept) begin
			key_c.peer_id    = req.peer_id;
			key_c.peer_epoch = req.peer_epoch;
		end
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		dff_cell #(
			.WINDOW_BITS (WINDOW_BITS),
			.CELL_ID     (i)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.key            (key_c),
			.scan_in        (scan_chain[i]),
			.scan_in_valid  (valid_chain[i]),
			.scan_out       (scan_chain[i+1]),
			.scan_out_valid (valid_chain[i+1]),
			.wr             (wr)
		);
	end

	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (valid_chain[TABLE_ENTRIES]) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = req.valid && req.ready;

	always_comb begin
		opened_c  = !fin.hit;
		evict_c   = 1'b0;
		verdict_c = 1'b0;
		old_bm    = fin.hit_bitmap[WB-1:0];
		new_hi_c  = fin.hit_highest;
		new_bm_c  = old_bm;
		adv       = seq_q - fin.hit_highest;
		age       = fin.hit_highest - seq_q;
		probe     = old_bm >> (age[5:0] - 6'd1);
		used_c    = fin.used;
		priority if (fin.hit) begin
			target_c = fin.hit_idx;
		end else if (fin.same) begin
			target_c = fin.same_idx;
		end else if (fin.free) begin
			target_c = fin.free_idx;
			used_c   = fin.used + DFF_CNT_MAX_W'(1);
		end else begin
			target_c = fin.lru_idx;
			evict_c  = 1'b1;
		end
		if (fin.hit) begin
			priority if (adv == 32'd0) begin
				verdict_c = 1'b1;
			end else if (adv < DFF_HALF_RANGE) begin
				new_hi_c = seq_q;
				priority if (adv > 32'(WB)) begin
					new_bm_c = '0;
				end else if (adv == 32'(WB)) begin
					new_bm_c = TOP_BIT;
				end else begin
					new_bm_c = (old_bm << adv[5:0]) | (ONE_BIT << (adv[5:0] - 6'd1));
				end
			end else begin
				if (age > 32'(WB)) begin
					verdict_c = 1'b1;
				end else if (probe[0]) begin
					verdict_c = 1'b1;
				end else begin
					new_bm_c = old_bm | (ONE_BIT << (age[5:0] - 6'd1));
				end
			end
		end
		used_sat = (used_c > DFF_CNT_MAX_W'(DFF_USED_MAX)) ? DFF_USED_MAX : used_c[4:0];
	end

	always_comb begin
		wr.en         = commit;
		wr.idx        = target_c;
		wr.peer_id    = key_q.peer_id;
		wr.peer_epoch = key_q.peer_epoch;
		wr.highest    = opened_c ? seq_q : new_hi_c;
		wr.bitmap     = opened_c ? '0 : DFF_WIN_MAX_W'(new_bm_c);
		wr.stamp      = stamp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stamp_q     <= 32'd1;
			evict_q     <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				stamp_q     <= (stamp_q == 32'hFFFF_FFFF) ? 32'd1 : stamp_q + 32'd1;
				out_valid_q <= 1'b1;
				if (evict_c) begin
					evict_q <= evict_q + 32'd1;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q.peer_id    <= req.peer_id;
			key_q.peer_epoch <= req.peer_epoch;
			seq_q            <= req.sequence_req;
		end
		if (commit) begin
			verdict_q <= verdict_c;
			opened_q  <= opened_c;
			evicted_q <= evict_c;
			used_q    <= used_sat;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.verdict        = verdict_q;
	assign rsp.opened_entry   = opened_q;
	assign rsp.evicted        = evicted_q;
	assign rsp.entries_used   = used_q;
	assign rsp.eviction_count = evict_q;

	`DFF_ASSERT_NOW(a_chain_end_in_scan, clk, arst_n, valid_chain[TABLE_ENTRIES], state_q == ST_SCAN, "scan result arrived outside the scan phase")
	`DFF_ASSERT_NOW(a_stamp_nonzero, clk, arst_n, 1'b1, stamp_q != 32'd0, "stamp clock reached zero")
	`DFF_ASSERT_NOW(a_evict_opens, clk, arst_n, rsp.valid && rsp.evicted, rsp.opened_entry, "eviction reported without a new entry")
	`DFF_ASSERT_NEXT(a_evict_count, clk, arst_n, commit && evict_c, evict_q == $past(evict_q) + 32'd1, "eviction total did not advance")

endmodule
`default_nettype wire

// ----- tb/duplicate_frame_filter_test.sv -----
// Self-checking testbench for the duplicate frame filter: it drives frames on the
// request channel and checks every verdict against an internal table predictor.
// Depends on dff_pkg, dff_if and duplicate_frame_filter.
`timescale 1ns / 100ps
`default_nettype none
module duplicate_frame_filter_test;
	import dff_pkg::*;

	localparam int NSLOTS = DFF_TABLE_ENTRIES;
	localparam int WIN = DFF_WINDOW_BITS;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic       verdict;
		logic       opened_entry;
		logic       evicted;
		logic [4:0] entries_used;
		logic [31:0] eviction_count;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	dff_req_if req ();
	dff_rsp_if rsp ();

	duplicate_frame_filter uut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [31:0] tab_stamp [NSLOTS];
	logic [31:0] tab_source [NSLOTS];
	logic [31:0] tab_session [NSLOTS];
	logic [31:0] tab_highest [NSLOTS];
	logic [31:0] tab_bitmap [NSLOTS];
	logic [31:0] recency;
	logic [31:0] evict_total;
	verdict_t pending_verdicts[$];
	int errors = 0;
	int cycles = 0;
	bit hold_rsp = 1'b0;
	bit quiet_rsp = 1'b0;
	logic [31:0] known_src [8];
	logic [31:0] known_ses [8];

	function automatic verdict_t judge_frame(logic [31:0] src, logic [31:0] ses,
			logic [31:0] seq);
		int hit, freeslot, same, lru, t, used;
		logic [31:0] adv, age, hi;
		verdict_t r;
		hit = -1; freeslot = -1; same = -1; lru = -1; used = 0;
		r = '0;
		for (int i = 0; i < NSLOTS; i++) begin
			if (tab_stamp[i] == 0) begin
				if (freeslot < 0) freeslot = i;
				continue;
			end
			if (tab_source[i] == src) begin
				if (tab_session[i] == ses) begin
					hit = i;
					break;
				end
				same = i;
			end
			if (lru < 0 || tab_stamp[i] < tab_stamp[lru]) lru = i;
		end
		if (hit >= 0) begin
			t = hit;
		end else begin
			if (same >= 0) t = same;
			else if (freeslot >= 0) t = freeslot;
			else begin
				t = lru;
				r.evicted = 1'b1;
				evict_total++;
			end
			tab_source[t] = src;
			tab_session[t] = ses;
			tab_highest[t] = seq;
			tab_bitmap[t] = '0;
			r.opened_entry = 1'b1;
		end
		tab_stamp[t] = recency;
		recency++;
		if (recency == 0) recency = 1;
		if (!r.opened_entry) begin
			hi = tab_highest[t];
			adv = seq - hi;
			age = hi - seq;
			if (seq == hi) begin
				r.verdict = 1'b1;
			end else if (adv < DFF_HALF_RANGE) begin
				if (adv > WIN) tab_bitmap[t] = '0;
				else if (adv == WIN) tab_bitmap[t] = 32'h1 << (WIN - 1);
				else tab_bitmap[t] = (tab_bitmap[t] << adv) | (32'h1 << (adv - 1));
				tab_highest[t] = seq;
			end else if (age > WIN) begin
				r.verdict = 1'b1;
			end else if (tab_bitmap[t][age-1]) begin
				r.verdict = 1'b1;
			end else begin
				tab_bitmap[t][age-1] = 1'b1;
			end
		end
		for (int i = 0; i < NSLOTS; i++)
			if (tab_stamp[i] != 0) used++;
		if (used > 31) used = 31;
		r.entries_used = 5'(used);
		r.eviction_count = evict_total;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic random_gap(int scale);
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40 * scale) :
			$urandom_range(0, 2);
		repeat (n) @(negedge clk);
	endtask

	task automatic send_frame(logic [31:0] src, logic [31:0] ses, logic [31:0] seq);
		req.valid = 1'b1;
		req.peer_id = src;
		req.peer_epoch = ses;
		req.sequence_req = seq;
		do @(posedge clk); while (!req.ready);
		pending_verdicts.push_back(judge_frame(src, ses, seq));
		@(negedge clk);
		req.valid = 1'b0;
	endtask

	task automatic drain_results();
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (NSLOTS + 8) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n || hold_rsp) rsp.ready <= 1'b0;
		else if (quiet_rsp) rsp.ready <= 1'b1;
		else rsp.ready <= ($urandom_range(0, 9) < 7);
	end

	always @(posedge clk) begin
		verdict_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("unexpected result", 32'd0, 32'd0);
			end else begin
				want = pending_verdicts.pop_front();
				if (rsp.verdict !== want.verdict)
					report_mismatch("verdict", 32'(rsp.verdict), 32'(want.verdict));
				if (rsp.opened_entry !== want.opened_entry)
					report_mismatch("opened_entry", 32'(rsp.opened_entry),
						32'(want.opened_entry));
				if (rsp.evicted !== want.evicted)
					report_mismatch("evicted", 32'(rsp.evicted), 32'(want.evicted));
				if (rsp.entries_used !== want.entries_used)
					report_mismatch("entries_used", 32'(rsp.entries_used),
						32'(want.entries_used));
				if (rsp.eviction_count !== want.eviction_count)
					report_mismatch("eviction_count", rsp.eviction_count,
						want.eviction_count);
			end
		end
	end

	task automatic test_window_edges();
		logic [31:0] base;
		base = 32'hFFFF_FFF0;
		quiet_rsp = 1'b1;
		send_frame(32'h0, 32'h0, base);
		send_frame(32'h0, 32'h0, base);
		send_frame(32'h0, 32'h0, base + 1);
		send_frame(32'h0, 32'h0, base - 31);
		send_frame(32'h0, 32'h0, base - 32);
		send_frame(32'h0, 32'h0, base - 32);
		send_frame(32'h0, 32'h0, base - 33);
		send_frame(32'h0, 32'h0, base + 33);
		send_frame(32'h0, 32'h0, base + 65);
		send_frame(32'h0, 32'h0, base + 65 + 32'h8000_0000);
		send_frame(32'h0, 32'h0, base + 64);
		send_frame(32'h0, 32'h0, base + 65 + 32'h7FFF_FFFF);
		send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_frame(32'hFFFF_FFFF, 32'h1, 32'h0);
		send_frame(32'hFFFF_FFFF, 32'h1, 32'h0);
		quiet_rsp = 1'b0;
	endtask

	task automatic test_table_fill_and_evict();
		for (int i = 0; i < NSLOTS + 6; i++)
			send_frame(32'h100 + i, 32'h5, $urandom);
		send_frame(32'h100 + NSLOTS + 5, 32'h6, 32'h0);
		drain_results();
	endtask

	task automatic test_backpressure();
		hold_rsp = 1'b1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_rsp = 1'b0;
			end
			for (int i = 0; i < 6; i++)
				send_frame(known_src[i % 8], known_ses[i % 8], $urandom_range(0, 40));
		join
		drain_results();
	endtask

	task automatic test_random_traffic(int count);
		int k;
		logic [31:0] seq;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(0, 7);
			if ($urandom_range(0, 19) == 0) known_ses[k] = $urandom;
			if ($urandom_range(0, 29) == 0) known_src[k] = $urandom;
			case ($urandom_range(0, 9))
				0: send_frame($urandom, $urandom, $urandom);
				1: begin
					seq = $urandom;
					send_frame(known_src[k], known_ses[k], seq);
				end
				default: send_frame(known_src[k], known_ses[k],
					32'h7FFF_FFE0 + $urandom_range(0, 80));
			endcase
			random_gap(1);
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.peer_id = '0;
		req.peer_epoch = '0;
		req.sequence_req = '0;
		for (int i = 0; i < NSLOTS; i++) tab_stamp[i] = '0;
		recency = 32'd1;
		evict_total = '0;
		for (int i = 0; i < 8; i++) begin
			known_src[i] = $urandom_range(0, 11);
			known_ses[i] = $urandom_range(0, 2);
		end
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_window_edges();
		test_table_fill_and_evict();
		test_backpressure();
		test_random_traffic(880);
		drain_results();
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/dff_pkg.sv
rtl/dff_if.sv
rtl/dff_cell.sv
rtl/duplicate_frame_filter.sv
tb/duplicate_frame_filter_test.sv
